### hdl/sto_pkg.sv
// ----------------------------------------------------------------------------
// sto_pkg : shared types and constants for the sorted timeout queue
// Word formats, opcodes, event kinds and the cell entry and control types.
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS     = 8;   // stored handle bits, at most 8

    // opcodes
    localparam logic [2:0] OP_DELAY     = 3'd0;
    localparam logic [2:0] OP_ARM       = 3'd1;
    localparam logic [2:0] OP_REM_TASK  = 3'd2;
    localparam logic [2:0] OP_REM_TIMER = 3'd3;
    localparam logic [2:0] OP_CHECK     = 3'd4;

    // event kinds
    localparam logic [2:0] EV_DONE  = 3'd0;
    localparam logic [2:0] EV_TASK  = 3'd1;
    localparam logic [2:0] EV_TIMER = 3'd2;
    localparam logic [2:0] EV_FULL  = 3'd3;
    localparam logic [2:0] EV_NONE  = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  handle;
        logic [31:0] duration;
        logic [31:0] period;
        logic        auto_reload;
        logic [31:0] now_tick;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  event_handle;
        logic [31:0] earliest_expiry;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        logic                   valid;
        logic                   is_timer;
        logic [HANDLE_BITS-1:0] handle;
        logic [31:0]            expiry;
        logic [31:0]            period;
        logic                   reload;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS,
        CMD_REM
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd              cmd;
        t_entry                 ins;        // word to insert, valid set
        logic                   rm_timer;   // kind to match on removal
        logic [HANDLE_BITS-1:0] rm_handle;  // handle to match on removal
    } t_cell_ctl;

endpackage

### hdl/sorted_timeout_queue.sv
// ----------------------------------------------------------------------------
// sorted_timeout_queue : timeout list kept sorted in a chain of cells
// Path from accepted word to result word: delay goes through MUL, INS, EMIT;
// arm through INS, EMIT; remove through REM, EMIT; check through CHK, EMIT
// (CHK, INS, EMIT for a reloading timer); spare opcodes straight to EMIT.
// One input word at a time; a check gives a further result per released task
// while the next head is due. Each step is one chain update, then one emit.
// Reset (synchronous, active low) empties the queue at once, ticks_per_ms = 1.
// ----------------------------------------------------------------------------
module sorted_timeout_queue
    import sto_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data
);

    // Sequencer states.
    //   IDLE : take a word
    //   MUL  : scale task delay and add to now
    //   INS  : insert r_ins into the chain (flags full instead)
    //   REM  : remove first match of kind and handle
    //   CHK  : pop the head if it is due
    //   EMIT : present the result, with head expiry read after the update
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_INS  = 6'b000100,
        S_REM  = 6'b001000,
        S_CHK  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    t_state          r_state;
    t_state          n_state;
    logic [15:0]     r_tpm;
    logic [31:0]     r_now;
    logic [47:0]     r_prod;
    t_entry          r_ins;
    logic            r_rm_timer;
    logic [2:0]      r_kind;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic            r_cont;      // released a task: the check carries on
    logic            r_out_valid;
    t_out_word       r_out;

    t_cell_ctl       w_ctl;
    t_entry          w_entry [QUEUE_DEPTH];
    logic            w_gt    [QUEUE_DEPTH];
    logic            w_hit   [QUEUE_DEPTH];
    logic            w_rm_head;
    t_entry          w_head;
    logic [31:0]     w_head_exp;
    logic            w_head_due;
    logic            w_full;
    logic            w_slot_free;
    logic [31:0]     w_prod_sat;

    // ---- chain of cells: index 0 is the head, earliest expiry ----
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_gt;
        logic   w_prev_hit;
        t_entry w_next;
        if (g == 0) begin : g_head
            assign w_prev     = '0;
            assign w_prev_gt  = 1'b0;
            assign w_prev_hit = w_rm_head;  // forces head pop on check
        end else begin : g_body
            assign w_prev     = w_entry[g-1];
            assign w_prev_gt  = w_gt[g-1];
            assign w_prev_hit = w_hit[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = '0;             // tail fills with an empty slot
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        sto_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev     (w_prev),
            .i_prev_gt  (w_prev_gt),
            .i_prev_hit (w_prev_hit),
            .i_next     (w_next),
            .o_entry    (w_entry[g]),
            .o_gt       (w_gt[g]),
            .o_hit      (w_hit[g])
        );
    end

    // ---- head status ----
    assign w_head      = w_entry[0];
    assign w_head_exp  = w_head.valid ? w_head.expiry : 32'd0;
    assign w_head_due  = w_head.valid && (w_head.expiry <= r_now);
    assign w_full      = w_entry[QUEUE_DEPTH-1].valid;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_prod_sat  = (|r_prod[47:32]) ? 32'hFFFF_FFFF : r_prod[31:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- sequencer and chain command ----
    always_comb begin
        n_state         = r_state;
        w_ctl.cmd       = CMD_HOLD;
        w_ctl.ins       = r_ins;
        w_ctl.rm_timer  = r_rm_timer;
        w_ctl.rm_handle = r_ins.handle;
        w_rm_head       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.opcode)
                        OP_DELAY:     n_state = S_MUL;
                        OP_ARM:       n_state = S_INS;
                        OP_REM_TASK:  n_state = S_REM;
                        OP_REM_TIMER: n_state = S_REM;
                        OP_CHECK:     n_state = S_CHK;
                        default:      n_state = S_EMIT;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_INS;
            end
            S_INS: begin
                if (!w_full) begin
                    w_ctl.cmd = CMD_INS;
                end
                n_state = S_EMIT;
            end
            S_REM: begin
                w_ctl.cmd = CMD_REM;
                n_state   = S_EMIT;
            end
            S_CHK: begin
                n_state = S_EMIT;
                if (w_head_due) begin
                    w_ctl.cmd = CMD_REM;
                    w_rm_head = 1'b1;
                    if (w_head.is_timer && w_head.reload) begin
                        n_state = S_INS;    // re-arm; the slot just freed
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = (r_cont && w_head_due) ? S_CHK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tpm       <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tpm <= i_cfg_wdata;
            end
            // EMIT reloads the slot itself
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_now           <= i_in_data.now_tick;
                        r_prod          <= 48'(i_in_data.duration) * 48'(r_tpm);
                        r_ins.valid     <= 1'b1;
                        r_ins.is_timer  <= (i_in_data.opcode == OP_ARM);
                        r_ins.handle    <= i_in_data.handle[HANDLE_BITS-1:0];
                        r_ins.expiry    <= sat_add(i_in_data.now_tick, i_in_data.duration);
                        r_ins.period    <= i_in_data.period;
                        r_ins.reload    <= i_in_data.auto_reload;
                        r_rm_timer      <= (i_in_data.opcode == OP_REM_TIMER);
                        r_kind          <= EV_DONE;
                        r_hdl           <= '0;
                        r_cont          <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_ins.expiry <= sat_add(r_now, w_prod_sat);
                end
                S_INS: begin
                    if (w_full) begin
                        r_kind <= EV_FULL;
                    end
                end
                S_CHK: begin
                    if (w_head_due) begin
                        r_kind         <= w_head.is_timer ? EV_TIMER : EV_TASK;
                        r_hdl          <= w_head.handle;
                        r_cont         <= !w_head.is_timer;
                        r_ins.valid    <= 1'b1;
                        r_ins.is_timer <= 1'b1;
                        r_ins.handle   <= w_head.handle;
                        r_ins.expiry   <= sat_add(w_head.expiry, w_head.period);
                        r_ins.period   <= w_head.period;
                        r_ins.reload   <= 1'b1;
                    end else begin
                        r_kind <= EV_NONE;
                        r_hdl  <= '0;
                        r_cont <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.event_kind      <= r_kind;
                        r_out.event_handle    <= 8'(r_hdl);
                        r_out.earliest_expiry <= w_head_exp;
                        r_out.last_result     <= !(r_cont && w_head_due);
                    end
                end
                default: begin
                    r_kind <= r_kind;
                end
            endcase
        end
    end

endmodule

### hdl/sto_cell.sv
// ----------------------------------------------------------------------------
// sto_cell : one slot of the sorted timeout chain
// Holds one entry; on insert shifts towards the tail, on removal shifts
// towards the head, as decided by the local compare and the hit chain.
// ----------------------------------------------------------------------------
module sto_cell
    import sto_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,      // entry of the cell nearer the head
    input  logic      i_prev_gt,   // nearer cell is past the insert point
    input  logic      i_prev_hit,  // removal point is at or before nearer cell
    input  t_entry    i_next,      // entry of the cell nearer the tail
    output t_entry    o_entry,
    output logic      o_gt,
    output logic      o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;

    assign o_entry = r_entry;

    always_comb begin
        o_gt    = !r_entry.valid || (r_entry.expiry > i_ctl.ins.expiry);
        w_match = r_entry.valid && (r_entry.is_timer == i_ctl.rm_timer)
                  && (r_entry.handle == i_ctl.rm_handle);
        o_hit   = i_prev_hit || w_match;
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_INS: begin
                if (i_prev_gt) begin
                    n_entry = i_prev;
                end else if (o_gt) begin
                    n_entry = i_ctl.ins;
                end
            end
            CMD_REM: begin
                if (o_hit) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
        // valid is control, the rest is payload
        if (!i_rst_n) begin
            n_entry.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### tb/sorted_timeout_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_tb : self-checking bench for the sorted timeout queue
// Drives delay, arm, remove and check words through the valid/ready ports.
// A local model of the sorted list predicts every result word, and each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_tb;
    import sto_pkg::*;

    localparam int          DEPTH         = QUEUE_DEPTH_DEF;
    localparam int          SETTLE_CYCLES = 12;      // spare margin after the last result word
    localparam int          HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [2:0]  OP_UNUSED_LO  = 3'd5;    // opcodes 5..7 are spare
    localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;
    localparam logic [31:0] TICK_MAX      = 32'hFFFF_FFFF;

    // ------------------------------------------------------------------------
    // DUT ports, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;

    sorted_timeout_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_entry      pend_list [$];        // model of the sorted list, head first
    t_out_word   expected_events [$];  // result words still to arrive
    logic [15:0] tick_scale = 16'd1;   // model copy of ticks_per_ms
    logic [31:0] tick_base  = 32'd1000;// running "now" for random words
    bit          idle_en    = 1'b0;    // random gaps on both sides
    logic        hold_req   = 1'b0;    // ask the receiver for a long hold-off
    int          hold_count = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          results_seen = 0;

    // ------------------------------------------------------------------------
    // Model of the list
    // ------------------------------------------------------------------------
    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TICK_MAX : s[31:0];
    endfunction

    // ties go after existing entries with the same expiry
    function automatic bit list_insert(t_entry e);
        int pos;
        if (pend_list.size() >= DEPTH)
            return 1'b0;
        pos = pend_list.size();
        for (int i = 0; i < pend_list.size(); i++) begin
            if (pend_list[i].expiry > e.expiry) begin
                pos = i;
                break;
            end
        end
        pend_list.insert(pos, e);
        return 1'b1;
    endfunction

    // result word as seen after the list update that caused it
    function automatic t_out_word event_word(logic [2:0] kind, logic [7:0] h);
        t_out_word r;
        r.event_kind      = kind;
        r.event_handle    = h;
        r.earliest_expiry = (pend_list.size() != 0) ? pend_list[0].expiry : 32'd0;
        r.last_result     = 1'b0;
        return r;
    endfunction

    function automatic void predict_word(t_in_word w);
        t_out_word              res [$];
        t_entry                 e;
        t_entry                 head;
        logic [63:0]            prod;
        logic [31:0]            delta;
        bit                     ok;
        logic [HANDLE_BITS-1:0] hdl;
        hdl = w.handle[HANDLE_BITS-1:0];
        e   = '0;
        case (w.opcode)
            OP_DELAY: begin
                prod     = 64'(w.duration) * 64'(tick_scale);
                delta    = (prod > 64'(TICK_MAX)) ? TICK_MAX : prod[31:0];
                e.valid  = 1'b1;
                e.handle = hdl;
                e.expiry = sat_add32(w.now_tick, delta);
                ok = list_insert(e);
                res.push_back(event_word(ok ? EV_DONE : EV_FULL, 8'd0));
            end
            OP_ARM: begin
                e.valid    = 1'b1;
                e.is_timer = 1'b1;
                e.handle   = hdl;
                e.expiry   = sat_add32(w.now_tick, w.duration);
                e.period   = w.period;
                e.reload   = w.auto_reload;
                ok = list_insert(e);
                res.push_back(event_word(ok ? EV_DONE : EV_FULL, 8'd0));
            end
            OP_REM_TASK, OP_REM_TIMER: begin
                // first entry of the named kind only
                for (int i = 0; i < pend_list.size(); i++) begin
                    if (pend_list[i].is_timer == (w.opcode == OP_REM_TIMER) &&
                        pend_list[i].handle == hdl) begin
                        pend_list.delete(i);
                        break;
                    end
                end
                res.push_back(event_word(EV_DONE, 8'd0));
            end
            OP_CHECK: begin
                // tasks drain one by one, the first timer ends the check
                while (pend_list.size() != 0 && pend_list[0].expiry <= w.now_tick &&
                       res.size() < DEPTH) begin
                    head = pend_list.pop_front();
                    if (head.is_timer) begin
                        if (head.reload) begin
                            head.expiry = sat_add32(head.expiry, head.period);
                            ok = list_insert(head);
                        end
                        res.push_back(event_word(EV_TIMER, 8'(head.handle)));
                        break;
                    end
                    res.push_back(event_word(EV_TASK, 8'(head.handle)));
                end
                if (res.size() == 0)
                    res.push_back(event_word(EV_NONE, 8'd0));
            end
            default: begin
                res.push_back(event_word(EV_DONE, 8'd0));
            end
        endcase
        res[res.size()-1].last_result = 1'b1;
        foreach (res[i])
            expected_events.push_back(res[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_word in_word(logic [2:0] op, logic [7:0] h, logic [31:0] dur,
                                         logic [31:0] per, logic rel, logic [31:0] now);
        t_in_word w;
        w.opcode      = op;
        w.handle      = h;
        w.duration    = dur;
        w.period      = per;
        w.auto_reload = rel;
        w.now_tick    = now;
        return w;
    endfunction

    // small handles so removes hit, small delays so checks release things
    function automatic t_in_word rand_word();
        t_in_word    w;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        w.handle      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        w.duration    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 60);
        w.period      = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 30);
        w.auto_reload = 1'($urandom_range(0, 1));
        w.now_tick    = ($urandom_range(0, 19) == 0) ? $urandom : tick_base;
        if (pick < 30) begin
            w.opcode = OP_DELAY;
        end else if (pick < 55) begin
            w.opcode = OP_ARM;
        end else if (pick < 65) begin
            w.opcode = OP_REM_TASK;
        end else if (pick < 75) begin
            w.opcode = OP_REM_TIMER;
        end else if (pick < 97) begin
            w.opcode   = OP_CHECK;
            tick_base  = tick_base + $urandom_range(0, 40);
            w.now_tick = tick_base;
            case ($urandom_range(0, 9))
                0: w.now_tick = TICK_MAX;     // flush everything due
                1: w.now_tick = $urandom;
                default: ;
            endcase
        end else begin
            w.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return w;
    endfunction

    // offer one word, predict on acceptance, maybe idle afterwards
    task automatic send_word(t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(w);
        words_sent++;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, wait for every predicted word, then idle for a spare margin
    task automatic settle();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ticks(logic [15:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tick_scale   = v;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // saturation at both ends, ties in arrival order
        send_word(in_word(OP_DELAY, 8'd1, 32'd0,    32'd0,    1'b0, 32'd1000));
        send_word(in_word(OP_DELAY, 8'd2, TICK_MAX, 32'd0,    1'b0, 32'd1000));
        send_word(in_word(OP_ARM,   8'd3, 32'd0,    32'd5,    1'b1, 32'd1000));
        send_word(in_word(OP_ARM,   8'd4, TICK_MAX, TICK_MAX, 1'b1, 32'hFFFF_FFF0));
        send_word(in_word(OP_ARM,   8'd5, 32'd10,   32'd0,    1'b1, 32'd1000));
        send_word(in_word(OP_DELAY, 8'd5, 32'd10,   32'd0,    1'b0, 32'd1000));
        send_word(in_word(OP_ARM,   8'd6, 32'd20,   32'd7,    1'b0, 32'd1000));
        // removes: a miss, then only the named kind goes
        send_word(in_word(OP_REM_TASK,  8'd9, 32'd0, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_REM_TIMER, 8'd5, 32'd0, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_REM_TASK,  8'd5, 32'd0, 32'd0, 1'b0, 32'd0));
        // nothing due, then a task released and the reloading timer stops the check
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, 32'd999));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, 32'd1000));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, 32'd1005));
        // zero period with reload comes back at the same expiry, behind its ties
        send_word(in_word(OP_ARM,   8'd7, 32'd20, 32'd0, 1'b1, 32'd1000));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0,  32'd0, 1'b0, 32'd1020));
        send_word(in_word(OP_REM_TIMER, 8'd3, 32'd0, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0,  32'd0, 1'b0, 32'd1020));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0,  32'd0, 1'b0, 32'd1020));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0,  32'd0, 1'b0, 32'd1020));
        send_word(in_word(OP_REM_TIMER, 8'd7, 32'd0, 32'd0, 1'b0, 32'd0));
        // spare opcodes with busy fields
        send_word(in_word(OP_UNUSED_LO,        8'hFF, TICK_MAX, TICK_MAX, 1'b1, TICK_MAX));
        send_word(in_word(OP_UNUSED_LO + 3'd1, 8'hA5, $urandom, $urandom, 1'b0, $urandom));
        send_word(in_word(OP_UNUSED_HI,        8'h5A, $urandom, $urandom, 1'b1, $urandom));
        // everything at the top of the tick range
        send_word(in_word(OP_DELAY, 8'hFF, TICK_MAX, TICK_MAX, 1'b1, TICK_MAX));
        send_word(in_word(OP_CHECK, 8'hFF, TICK_MAX, TICK_MAX, 1'b1, TICK_MAX));
        send_word(in_word(OP_REM_TIMER, 8'd4, 32'd0, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, TICK_MAX));
    endtask

    // 17 inserts always overflow a 16 deep list, then an arm and two full checks
    task automatic test_queue_full();
        for (int i = 0; i < DEPTH + 1; i++)
            send_word(in_word(OP_DELAY, 8'($urandom), $urandom_range(0, 50), 32'd0,
                              1'b0, tick_base));
        send_word(in_word(OP_ARM, 8'd0, 32'd1, 32'd1, 1'b1, tick_base));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, TICK_MAX));
        send_word(in_word(OP_CHECK, 8'd0, 32'd0, 32'd0, 1'b0, TICK_MAX));
    endtask

    task automatic test_tick_scale();
        // zero scale: a delay is due at once
        write_ticks(16'd0);
        send_word(in_word(OP_DELAY, 8'd10, 32'd12345, 32'd0, 1'b0, 32'd500));
        send_word(in_word(OP_CHECK, 8'd0,  32'd0,     32'd0, 1'b0, 32'd500));
        // top scale: product saturation and a product that fits
        write_ticks(16'hFFFF);
        send_word(in_word(OP_DELAY, 8'd11, TICK_MAX,  32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_DELAY, 8'd12, 32'd65536, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_DELAY, 8'd13, 32'd65538, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_DELAY, 8'd14, 32'd3,     32'd0, 1'b0, 32'd100));
        send_word(in_word(OP_CHECK, 8'd0,  32'd0,     32'd0, 1'b0, 32'd196705));
        send_word(in_word(OP_CHECK, 8'd0,  32'd0,     32'd0, 1'b0, TICK_MAX));
        write_ticks(16'd1000);
        send_word(in_word(OP_DELAY, 8'd15, 32'd2, 32'd0, 1'b0, 32'd0));
        send_word(in_word(OP_CHECK, 8'd0,  32'd0, 32'd0, 1'b0, 32'd1999));
        send_word(in_word(OP_CHECK, 8'd0,  32'd0, 32'd0, 1'b0, 32'd2000));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_word());
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure();
        settle();
        idle_en   = 1'b0;
        hold_req <= 1'b1;
        for (int i = 0; i < 20; i++)
            send_word(rand_word());
        settle();
        hold_req <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            i_out_ready <= 1'b0;
            hold_count  <= hold_count + 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
        if (!hold_req)
            hold_count <= 0;
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with none expected: kind %0d handle %0d",
                             $realtime, o_out_data.event_kind, o_out_data.event_handle);
            end else begin
                want = expected_events.pop_front();
                if (o_out_data.event_kind      !== want.event_kind      ||
                    o_out_data.event_handle    !== want.event_handle    ||
                    o_out_data.earliest_expiry !== want.earliest_expiry ||
                    o_out_data.last_result     !== want.last_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch exp kind %0d hdl %0d head %h last %0d,",
                                  " got kind %0d hdl %0d head %h last %0d"},
                                 $realtime, want.event_kind, want.event_handle,
                                 want.earliest_expiry, want.last_result,
                                 o_out_data.event_kind, o_out_data.event_handle,
                                 o_out_data.earliest_expiry, o_out_data.last_result);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        idle_en = 1'b1;
        test_queue_full();
        test_tick_scale();
        write_ticks(16'd1);
        test_random(80);
        test_backpressure();
        idle_en = 1'b1;
        write_ticks(16'($urandom_range(1, 16'hFFFF)));
        test_random(40);
        // closing stretch at full rate, no idling either side
        write_ticks(16'd1);
        idle_en = 1'b0;
        test_random(40);
        settle();

        $display("sent %0d words, checked %0d result words, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("tick scales 0, 1, 1000, 65535 and one random; list overflow and long stall");
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
